// ===== hw/rtl/igmpv2_host_group_table_defines.svh =====
// Assertion macros shared by the group table checker
`ifndef IGMPV2_HOST_GROUP_TABLE_DEFINES_SVH
`define IGMPV2_HOST_GROUP_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define IGMP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define IGMP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/igmp_hgt_pkg.sv =====
// Types, constants and helper functions for the IGMPv2 host group table
`default_nettype none

package igmp_hgt_pkg;

  localparam int GROUPS = 16;
  localparam int IDX_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int CNT_W  = $clog2(GROUPS + 1);

  localparam logic [31:0] ALL_SYSTEMS = 32'hE000_0001;
  localparam logic [31:0] ALL_ROUTERS = 32'hE000_0002;

  localparam int          PADDR_W           = 3;
  localparam logic [0:0]  REG_JOIN_DELAY    = 1'b0;
  localparam logic [0:0]  REG_V1_DELAY      = 1'b1;
  localparam logic [7:0]  JOIN_DELAY_RESET  = 8'd5;
  localparam logic [7:0]  V1_DELAY_RESET    = 8'd100;

  typedef enum logic [2:0] {
    OP_JOIN   = 3'd0,
    OP_LEAVE  = 3'd1,
    OP_QUERY  = 3'd2,
    OP_REPORT = 3'd3,
    OP_TICK   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_FULL       = 2'd1,
    STAT_NOT_MEMBER = 2'd2,
    STAT_NOT_OURS   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MS_NON      = 2'd0,
    MS_DELAYING = 2'd1,
    MS_IDLE     = 2'd2
  } mstate_t;

  typedef enum logic [1:0] {
    FLT_NONE = 2'd0,
    FLT_ADD  = 2'd1,
    FLT_DEL  = 2'd2
  } filter_t;

  typedef enum logic {
    KIND_REPORT = 1'b0,
    KIND_LEAVE  = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FINISH
  } seq_state_t;

  typedef enum logic [1:0] {
    MD_IMM,
    MD_SEARCH,
    MD_TICK,
    MD_GQ
  } mode_t;

  typedef struct packed {
    logic [31:0] addr;
    mstate_t     mstate;
    logic [7:0]  timer;
    logic [7:0]  uses;
    logic        rlast;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] raddr;
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
  } mem_req_t;

  typedef struct packed {
    status_t     status;
    logic        send_valid;
    kind_t       send_kind;
    logic [31:0] send_dest;
    logic [31:0] msg_group;
    filter_t     filter;
    logic        last;
  } result_t;

  function automatic logic [7:0] delay_from(input logic [7:0] max_ticks);
    logic [7:0] t;
    t = {1'b0, max_ticks[7:1]};
    return (t == 8'd0) ? 8'd1 : t;
  endfunction

  function automatic entry_t maybe_delay(input entry_t e, input logic [7:0] m);
    entry_t r;
    r = e;
    if (e.mstate == MS_IDLE ||
        (e.mstate == MS_DELAYING && (e.timer == 8'd0 || m < e.timer))) begin
      r.timer  = delay_from(m);
      r.mstate = MS_DELAYING;
    end
    return r;
  endfunction

  function automatic result_t ok_result();
    result_t r;
    r.status     = STAT_OK;
    r.send_valid = 1'b0;
    r.send_kind  = KIND_REPORT;
    r.send_dest  = 32'd0;
    r.msg_group  = 32'd0;
    r.filter     = FLT_NONE;
    r.last       = 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/igmp_hgt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read
`default_nettype none

module igmp_hgt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/igmp_hgt_seq.sv =====
// Sequencer: walks the group table memory, updates entries, builds results
`default_nettype none

module igmp_hgt_seq
  import igmp_hgt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  op,
  input  logic [31:0] dest_addr,
  input  logic [31:0] group_addr,
  input  logic [7:0]  max_resp,
  input  logic [7:0]  join_delay,
  input  logic [7:0]  v1_delay,
  output mem_req_t    mem_req,
  input  entry_t      rdata,
  output logic        out_valid,
  input  logic        out_ready,
  output result_t     out_res
);

  seq_state_t state, state_next;
  mode_t      mode, mode_next;

  logic [2:0]       op_q;
  logic [31:0]      dest_q, grp_q, key_q;
  logic [7:0]       mr_q;
  logic [CNT_W-1:0] rd_ptr;
  logic             dvalid;
  logic [IDX_W-1:0] dv_idx;
  logic             found, free_found;
  logic [IDX_W-1:0] fidx, free_idx;
  entry_t           fdata;
  logic             pend_valid;
  logic [31:0]      pend_grp;
  logic [GROUPS-1:0] valid;

  logic       can_load, accept, ptr_end, issue, stall;
  logic       ev_valid, eval_we, fire;
  entry_t     wr_e;
  logic [7:0] gq_m;
  result_t    fin_res, load_res;
  logic       fin_we, set_v, clr_v, out_load;
  logic [IDX_W-1:0] fin_waddr;
  entry_t     fin_wdata;
  logic [31:0] key_next;

  assign can_load = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign ptr_end  = (rd_ptr == CNT_W'(GROUPS));
  assign gq_m     = (mr_q == 8'd0) ? v1_delay : mr_q;

  // Mode and search key for a new transaction
  always_comb begin
    mode_next = MD_IMM;
    key_next  = dest_addr;
    case (op)
      OP_JOIN, OP_LEAVE: begin
        mode_next = (group_addr == ALL_SYSTEMS) ? MD_IMM : MD_SEARCH;
        key_next  = group_addr;
      end
      OP_QUERY: begin
        if (dest_addr == ALL_SYSTEMS) begin
          mode_next = (group_addr == 32'd0) ? MD_GQ : MD_SEARCH;
          key_next  = group_addr;
        end else begin
          mode_next = MD_SEARCH;
        end
      end
      OP_REPORT: mode_next = (dest_addr == ALL_SYSTEMS) ? MD_IMM : MD_SEARCH;
      OP_TICK:   mode_next = MD_TICK;
      default:   mode_next = MD_IMM;
    endcase
  end

  // Per-entry evaluation during a walk
  always_comb begin
    ev_valid = dvalid && valid[dv_idx];
    wr_e     = rdata;
    eval_we  = 1'b0;
    fire     = 1'b0;
    if (mode == MD_TICK) begin
      if (ev_valid && rdata.timer != 8'd0) begin
        eval_we    = 1'b1;
        wr_e.timer = rdata.timer - 8'd1;
        if (wr_e.timer == 8'd0 && rdata.mstate == MS_DELAYING) begin
          fire        = 1'b1;
          wr_e.mstate = MS_IDLE;
          wr_e.rlast  = 1'b1;
        end
      end
    end else if (mode == MD_GQ) begin
      if (ev_valid) begin
        eval_we = 1'b1;
        wr_e    = maybe_delay(rdata, gq_m);
      end
    end
    // hold the walk while an earlier report cannot move to the output
    stall = (state == S_WALK) && fire && pend_valid && !can_load;
    issue = (state == S_WALK) && !stall && !ptr_end;
  end

  // Final result and write-back of a transaction
  always_comb begin
    fin_res   = ok_result();
    fin_we    = 1'b0;
    fin_waddr = fidx;
    fin_wdata = fdata;
    set_v     = 1'b0;
    clr_v     = 1'b0;
    case (mode)
      MD_TICK: begin
        if (pend_valid) begin
          fin_res.send_valid = 1'b1;
          fin_res.send_dest  = pend_grp;
          fin_res.msg_group  = pend_grp;
        end
      end
      MD_SEARCH: begin
        case (op_q)
          OP_JOIN: begin
            if (found) begin
              fin_we = 1'b1;
              if (fdata.uses != 8'hFF) begin
                fin_wdata.uses = fdata.uses + 8'd1;
              end
            end else if (free_found) begin
              fin_we           = 1'b1;
              set_v            = 1'b1;
              fin_waddr        = free_idx;
              fin_wdata.addr   = grp_q;
              fin_wdata.mstate = MS_DELAYING;
              fin_wdata.timer  = delay_from(join_delay);
              fin_wdata.uses   = 8'd1;
              fin_wdata.rlast  = 1'b1;
              fin_res.send_valid = 1'b1;
              fin_res.send_dest  = grp_q;
              fin_res.msg_group  = grp_q;
              fin_res.filter     = FLT_ADD;
            end else begin
              fin_res.status = STAT_FULL;
            end
          end
          OP_LEAVE: begin
            if (!found) begin
              fin_res.status = STAT_NOT_MEMBER;
            end else if (fdata.uses <= 8'd1) begin
              clr_v             = 1'b1;
              fin_res.msg_group = grp_q;
              fin_res.filter    = FLT_DEL;
              if (fdata.rlast) begin
                fin_res.send_valid = 1'b1;
                fin_res.send_kind  = KIND_LEAVE;
                fin_res.send_dest  = ALL_ROUTERS;
              end
            end else begin
              fin_we         = 1'b1;
              fin_wdata.uses = fdata.uses - 8'd1;
            end
          end
          OP_QUERY: begin
            if (dest_q != ALL_SYSTEMS && !found) begin
              fin_res.status = STAT_NOT_OURS;
            end else if (found && grp_q != 32'd0) begin
              fin_we    = 1'b1;
              fin_wdata = maybe_delay(fdata, mr_q);
            end
          end
          OP_REPORT: begin
            if (!found) begin
              fin_res.status = STAT_NOT_OURS;
            end else if (fdata.mstate == MS_DELAYING) begin
              fin_we           = 1'b1;
              fin_wdata.timer  = 8'd0;
              fin_wdata.mstate = MS_IDLE;
              fin_wdata.rlast  = 1'b0;
            end
          end
          default: fin_res = ok_result();
        endcase
      end
      default: fin_res = ok_result();
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept) state_next = (mode_next == MD_IMM) ? S_FINISH : S_WALK;
      S_WALK:   if (dvalid && !stall && ptr_end) state_next = S_FINISH;
      S_FINISH: if (can_load) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Memory port and output register load
  always_comb begin
    mem_req.re    = issue;
    mem_req.raddr = rd_ptr[IDX_W-1:0];
    mem_req.we    = 1'b0;
    mem_req.waddr = dv_idx;
    mem_req.wdata = wr_e;
    out_load      = 1'b0;
    load_res      = fin_res;
    if (state == S_FINISH) begin
      out_load = can_load;
      if (can_load) begin
        mem_req.we    = fin_we;
        mem_req.waddr = fin_waddr;
        mem_req.wdata = fin_wdata;
      end
    end else if (state == S_WALK) begin
      mem_req.we = eval_we && !stall;
      if (fire && pend_valid && can_load) begin
        // push the previous report out; it is not the last one
        out_load           = 1'b1;
        load_res           = ok_result();
        load_res.last      = 1'b0;
        load_res.send_valid = 1'b1;
        load_res.send_dest = pend_grp;
        load_res.msg_group = pend_grp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      mode       <= MD_IMM;
      rd_ptr     <= '0;
      dvalid     <= 1'b0;
      found      <= 1'b0;
      free_found <= 1'b0;
      pend_valid <= 1'b0;
      valid      <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        mode       <= mode_next;
        rd_ptr     <= '0;
        dvalid     <= 1'b0;
        found      <= 1'b0;
        free_found <= 1'b0;
        pend_valid <= 1'b0;
      end else if (state == S_WALK && !stall) begin
        if (issue) begin
          rd_ptr <= rd_ptr + CNT_W'(1);
          dvalid <= 1'b1;
        end else begin
          dvalid <= 1'b0;
        end
        if (mode == MD_SEARCH && dvalid) begin
          if (valid[dv_idx] && rdata.addr == key_q && !found) begin
            found <= 1'b1;
          end
          if (!valid[dv_idx] && !free_found) begin
            free_found <= 1'b1;
          end
        end
        if (fire) begin
          pend_valid <= 1'b1;
        end
      end
      if (state == S_FINISH && can_load) begin
        if (set_v) valid[free_idx] <= 1'b1;
        if (clr_v) valid[fidx] <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= op;
      dest_q <= dest_addr;
      grp_q  <= group_addr;
      mr_q   <= max_resp;
      key_q  <= key_next;
    end
    if (issue) begin
      dv_idx <= rd_ptr[IDX_W-1:0];
    end
    if (state == S_WALK && !stall && mode == MD_SEARCH && dvalid) begin
      if (valid[dv_idx] && rdata.addr == key_q && !found) begin
        fidx  <= dv_idx;
        fdata <= rdata;
      end
      if (!valid[dv_idx] && !free_found) begin
        free_idx <= dv_idx;
      end
    end
    if (state == S_WALK && !stall && fire) begin
      pend_grp <= rdata.addr;
    end
    if (out_load) begin
      out_res <= load_res;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/igmpv2_host_group_table.sv =====
// Top level of the IGMPv2 host group table: config registers, table memory, sequencer
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_ready  | op, dest_addr, group_addr, max_resp
//  out     | output    | out_valid/out_ready| status, send_valid, send_kind, send_dest,
//          |           |                    | msg_group, filter_action, last_result
//  cfg     | input     | psel/penable/pready| paddr, pwdata, prdata (APB)
//
// One transaction at a time. Join, leave, report and specific query read all
// GROUPS entries through the one table read port, then write back. Tick and
// general query read each entry and rewrite valid entries as needed in the same walk.
// Transactions that touch no entry skip the walk. A full output register stalls
// the walk only when a tick fires a second report. Synchronous reset clears the
// valid bits directly; no clearing pass.
`default_nettype none

module igmpv2_host_group_table
  import igmp_hgt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         op,
  input  logic [31:0]        dest_addr,
  input  logic [31:0]        group_addr,
  input  logic [7:0]         max_resp,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic               send_valid,
  output logic               send_kind,
  output logic [31:0]        send_dest,
  output logic [31:0]        msg_group,
  output logic [1:0]         filter_action,
  output logic               last_result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [7:0] join_delay, v1_delay;
  mem_req_t   mem_req;
  entry_t     rdata;
  result_t    res;
  logic [ENTRY_W-1:0] rdata_raw;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      join_delay <= JOIN_DELAY_RESET;
      v1_delay   <= V1_DELAY_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2:2])
        REG_JOIN_DELAY: join_delay <= pwdata[7:0];
        REG_V1_DELAY:   v1_delay   <= pwdata[7:0];
        default:        join_delay <= join_delay;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2:2])
      REG_JOIN_DELAY: prdata = {24'd0, join_delay};
      REG_V1_DELAY:   prdata = {24'd0, v1_delay};
      default:        prdata = 32'd0;
    endcase
  end

  igmp_hgt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(GROUPS)
  ) u_table (
    .clk  (clk),
    .we   (mem_req.we),
    .waddr(mem_req.waddr),
    .wdata(mem_req.wdata),
    .re   (mem_req.re),
    .raddr(mem_req.raddr),
    .rdata(rdata_raw)
  );

  assign rdata = entry_t'(rdata_raw);

  igmp_hgt_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .dest_addr (dest_addr),
    .group_addr(group_addr),
    .max_resp  (max_resp),
    .join_delay(join_delay),
    .v1_delay  (v1_delay),
    .mem_req   (mem_req),
    .rdata     (rdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign status        = res.status;
  assign send_valid    = res.send_valid;
  assign send_kind     = res.send_kind;
  assign send_dest     = res.send_dest;
  assign msg_group     = res.msg_group;
  assign filter_action = res.filter;
  assign last_result   = res.last;

endmodule

`default_nettype wire

// ===== hw/rtl/igmp_hgt_checker.sv =====
// Port-level checker for the group table, bound to the top level
`default_nettype none
`include "igmpv2_host_group_table_defines.svh"

module igmp_hgt_checker
  import igmp_hgt_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [1:0]         status,
  input wire logic               send_valid,
  input wire logic               send_kind,
  input wire logic [31:0]        send_dest,
  input wire logic [31:0]        msg_group,
  input wire logic [1:0]         filter_action,
  input wire logic               last_result
);

  `IGMP_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "input taken while busy")
  `IGMP_ASSERT_NOW(a_add_reports, out_valid && filter_action == FLT_ADD, send_valid && send_dest == msg_group && status == STAT_OK, "filter add without report")
  `IGMP_ASSERT_NOW(a_leave_form, out_valid && send_kind == KIND_LEAVE, send_valid && send_dest == ALL_ROUTERS && filter_action == FLT_DEL, "malformed leave")
  `IGMP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(msg_group) && $stable(last_result), "result dropped while stalled")

endmodule

bind igmpv2_host_group_table igmp_hgt_checker u_chk (.*);

`default_nettype wire
